// ===== rtl/qsh3_pkg.sv =====
// ----------------------------------------------------------------------------
// qsh3_pkg
// Shared types and constants for the median-of-three quicksort block.
// ----------------------------------------------------------------------------
`default_nettype none

package qsh3_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

`default_nettype wire

// ===== rtl/qsh3_if.sv =====
// ----------------------------------------------------------------------------
// qsh3 channel interfaces
// Valid/ready channels for input samples and sorted results.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsh3_in_if
  import qsh3_pkg::*;
;
  logic   valid;
  logic   ready;
  value_t sample_value;
  logic   final_item;

  modport source (output valid, output sample_value, output final_item, input ready);
  modport sink   (input valid, input sample_value, input final_item, output ready);
endinterface

interface qsh3_out_if
  import qsh3_pkg::*;
;
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   end_of_set;

  modport source (output valid, output sorted_value, output end_of_set, input ready);
  modport sink   (input valid, input sorted_value, input end_of_set, output ready);
endinterface

`default_nettype wire

// ===== rtl/quicksort_hoare_median3.sv =====
// ----------------------------------------------------------------------------
// quicksort_hoare_median3
// Collects signed values, sorts them by iterative quicksort with a Hoare
// partition and a median-of-three pivot, then emits them in ascending order.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                        Transfer
//  in_ch    sink       sample_value, final_item       valid && ready
//  out_ch   source     sorted_value, end_of_set       valid && ready
//
//  Loading accepts one value per cycle; the block is ready only while idle.
//  Sorting uses one memory read port: each range has its low, middle and
//  high values read, ordered for the pivot and written back, then partitioned
//  by scans and swaps. Emitting reads each value, then loads it for output.
//  Reset clears the control state only; the value store is not cleared.
//  A stall on the output holds the sequencer until the transfer happens.
`default_nettype none

module quicksort_hoare_median3
  import qsh3_pkg::*;
#(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned STACK_ENTRIES = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  qsh3_in_if.sink     in_ch,
  qsh3_out_if.source  out_ch
);

  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned SPW = $clog2(STACK_ENTRIES + 1);
  localparam int unsigned SIW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

  typedef logic [IW-1:0] idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_P_R0, ST_P_R1, ST_P_R2, ST_P_C, ST_S1, ST_S2, ST_S3,
    ST_W1, ST_W2, ST_W3, ST_I_RD, ST_I_CMP, ST_J_RD, ST_J_CMP,
    ST_SW1, ST_SW2, ST_DEC, ST_POP, ST_O_RD, ST_O_LD
  } state_t;

  state_t state_r;

  value_t mem [CAPACITY];
  value_t rd_q_r;
  logic   mem_we;
  idx_t   mem_wa;
  idx_t   mem_ra;
  value_t mem_wd;

  logic [2*IW-1:0] stack_r [STACK_ENTRIES];

  logic [CW-1:0]  count_r;
  logic [SPW-1:0] sp_r;
  idx_t   last_idx_r, lo_r, hi_r, i_r, j_r, k_r;
  value_t va_r, vm_r, vh_r, vi_r, vj_r, piv_r;
  logic   out_valid_r, out_last_r;
  value_t out_data_r;

  logic            in_xfer, ends_set, adj, free, at_last;
  logic [CW-1:0]   n_cnt;
  idx_t            mid, p_w;
  logic [SPW-1:0]  sp_m1;
  logic [2*IW-1:0] top;
  idx_t            pop_lo, pop_hi;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign n_cnt             = count_r + CW'(1);
  assign ends_set          = in_ch.final_item || (n_cnt == CW'(CAPACITY));
  assign mid               = lo_r + ((hi_r - lo_r) >> 1);
  assign adj               = (mid == lo_r);
  assign p_w               = (j_r >= hi_r) ? (hi_r - idx_t'(1)) : j_r;
  assign sp_m1             = sp_r - SPW'(1);
  assign top               = stack_r[sp_m1[SIW-1:0]];
  assign pop_lo            = top[2*IW-1:IW];
  assign pop_hi            = (top[IW-1:0] > last_idx_r) ? last_idx_r : top[IW-1:0];
  assign free              = !out_valid_r || out_ch.ready;
  assign at_last           = (k_r == last_idx_r);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_data_r;
  assign out_ch.end_of_set   = out_last_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = lo_r;
    mem_wd = vm_r;
    mem_ra = lo_r;
    case (state_r)
      ST_IDLE: begin
        mem_we = in_xfer;
        mem_wa = count_r[IW-1:0];
        mem_wd = in_ch.sample_value;
      end
      ST_P_R1: mem_ra = mid;
      ST_P_R2: mem_ra = hi_r;
      ST_W1: begin
        mem_we = 1'b1;
        mem_wd = adj ? va_r : vm_r;
      end
      ST_W2: begin
        mem_we = 1'b1;
        mem_wa = mid;
        mem_wd = va_r;
      end
      ST_W3: begin
        mem_we = 1'b1;
        mem_wa = hi_r;
        mem_wd = vh_r;
      end
      ST_I_RD: mem_ra = i_r;
      ST_J_RD: mem_ra = j_r;
      ST_SW1: begin
        mem_we = 1'b1;
        mem_wa = i_r;
        mem_wd = vj_r;
      end
      ST_SW2: begin
        mem_we = 1'b1;
        mem_wa = j_r;
        mem_wd = vi_r;
      end
      ST_O_RD, ST_O_LD: mem_ra = k_r;
      default: mem_ra = lo_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && (state_r != ST_O_LD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (ends_set) begin
              count_r    <= '0;
              last_idx_r <= count_r[IW-1:0];
              lo_r       <= '0;
              hi_r       <= count_r[IW-1:0];
              sp_r       <= '0;
              k_r        <= '0;
              state_r    <= (count_r == '0) ? ST_O_RD : ST_P_R0;
            end else begin
              count_r <= n_cnt;
            end
          end
        end
        ST_P_R0: state_r <= ST_P_R1;
        ST_P_R1: begin
          va_r    <= rd_q_r;
          state_r <= ST_P_R2;
        end
        ST_P_R2: begin
          vm_r    <= rd_q_r;
          state_r <= ST_P_C;
        end
        ST_P_C: begin
          vh_r    <= rd_q_r;
          state_r <= ST_S1;
        end
        ST_S1: begin
          if (va_r > vm_r) begin
            va_r <= vm_r;
            vm_r <= va_r;
          end
          state_r <= ST_S2;
        end
        ST_S2: begin
          if (va_r > vh_r) begin
            va_r <= vh_r;
            vh_r <= va_r;
          end
          state_r <= adj ? ST_W1 : ST_S3;
        end
        ST_S3: begin
          if (vm_r > vh_r) begin
            vm_r <= vh_r;
            vh_r <= vm_r;
          end
          state_r <= ST_W1;
        end
        ST_W1: begin
          piv_r   <= adj ? va_r : vm_r;
          state_r <= adj ? ST_W3 : ST_W2;
        end
        ST_W2: state_r <= ST_W3;
        ST_W3: begin
          i_r     <= lo_r;
          j_r     <= hi_r;
          state_r <= ST_I_RD;
        end
        ST_I_RD: state_r <= ST_I_CMP;
        ST_I_CMP: begin
          if ((i_r < hi_r) && (rd_q_r < piv_r)) begin
            i_r     <= i_r + idx_t'(1);
            state_r <= ST_I_RD;
          end else begin
            vi_r    <= rd_q_r;
            state_r <= ST_J_RD;
          end
        end
        ST_J_RD: state_r <= ST_J_CMP;
        ST_J_CMP: begin
          if ((j_r > lo_r) && (rd_q_r > piv_r)) begin
            j_r     <= j_r - idx_t'(1);
            state_r <= ST_J_RD;
          end else begin
            vj_r    <= rd_q_r;
            state_r <= (i_r >= j_r) ? ST_DEC : ST_SW1;
          end
        end
        ST_SW1: state_r <= ST_SW2;
        ST_SW2: begin
          i_r     <= i_r + idx_t'(1);
          j_r     <= j_r - idx_t'(1);
          state_r <= ST_I_RD;
        end
        ST_DEC: begin
          if ((p_w > lo_r) && (hi_r > p_w + idx_t'(1))) begin
            if ((p_w - lo_r + idx_t'(1)) >= (hi_r - p_w)) begin
              if (sp_r < SPW'(STACK_ENTRIES)) begin
                stack_r[sp_r[SIW-1:0]] <= {lo_r, p_w};
                sp_r <= sp_r + SPW'(1);
              end
              lo_r <= p_w + idx_t'(1);
            end else begin
              if (sp_r < SPW'(STACK_ENTRIES)) begin
                stack_r[sp_r[SIW-1:0]] <= {p_w + idx_t'(1), hi_r};
                sp_r <= sp_r + SPW'(1);
              end
              hi_r <= p_w;
            end
            state_r <= ST_P_R0;
          end else if (p_w > lo_r) begin
            hi_r    <= p_w;
            state_r <= ST_P_R0;
          end else if (hi_r > p_w + idx_t'(1)) begin
            lo_r    <= p_w + idx_t'(1);
            state_r <= ST_P_R0;
          end else begin
            state_r <= ST_POP;
          end
        end
        ST_POP: begin
          if (sp_r == '0) begin
            k_r     <= '0;
            state_r <= ST_O_RD;
          end else begin
            sp_r <= sp_m1;
            lo_r <= pop_lo;
            hi_r <= pop_hi;
            if (pop_lo < pop_hi) begin
              state_r <= ST_P_R0;
            end
          end
        end
        ST_O_RD: state_r <= ST_O_LD;
        ST_O_LD: begin
          if (free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= rd_q_r;
            out_last_r  <= at_last;
            k_r         <= k_r + idx_t'(1);
            state_r     <= at_last ? ST_IDLE : ST_O_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_ENTRIES))
    else $error("range stack overflow");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_I_CMP || state_r == ST_J_CMP) |->
      (i_r >= lo_r && i_r <= hi_r && j_r >= lo_r && j_r <= hi_r))
    else $error("partition index left its range");

  a_set_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && ends_set) |=> (state_r != ST_IDLE))
    else $error("set end did not start the sort");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CW'(CAPACITY))
    else $error("element count reached capacity");

endmodule

`default_nettype wire

// ===== tb/sv/qsh3_sort_board.sv =====
// ----------------------------------------------------------------------------
// qsh3_sort_board
// Collects accepted samples into the current set, sorts each finished set
// into the queue of values due, and checks every sorted transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class qsh3_sort_board;
  localparam int unsigned CAPACITY = 64;

  logic signed [31:0] pending_set[$];
  logic signed [31:0] due_value[$];
  logic               due_last[$];
  int unsigned        error_count;

  function void note_sample(logic signed [31:0] value, logic last);
    logic signed [31:0] t;
    pending_set.push_back(value);
    if (last || pending_set.size() == CAPACITY) begin
      for (int a = 1; a < pending_set.size(); a++) begin
        for (int b = a; b > 0 && pending_set[b-1] > pending_set[b]; b--) begin
          t = pending_set[b];
          pending_set[b] = pending_set[b-1];
          pending_set[b-1] = t;
        end
      end
      foreach (pending_set[k]) begin
        due_value.push_back(pending_set[k]);
        due_last.push_back(k == pending_set.size() - 1);
      end
      pending_set.delete();
    end
  endfunction

  function void check_sorted(logic signed [31:0] value, logic last);
    logic signed [31:0] exp_value;
    logic               exp_last;
    if (due_value.size() == 0) begin
      $display("%0t: unexpected result value=%0d last=%0b", $time, value, last);
      error_count++;
      return;
    end
    exp_value = due_value.pop_front();
    exp_last  = due_last.pop_front();
    if (value !== exp_value || last !== exp_last) begin
      $display("%0t: mismatch expected value=%0d last=%0b actual value=%0d last=%0b",
               $time, exp_value, exp_last, value, last);
      error_count++;
    end
  endfunction
endclass

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives sets of signed samples into the quicksort block, mostly with random
// idle gaps on both sides, and checks each set comes back in ascending order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import qsh3_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qsh3_in_if  in_ch ();
  qsh3_out_if out_ch ();

  quicksort_hoare_median3 u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  qsh3_sort_board board = new();
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 62;
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        board.check_sorted(out_ch.sorted_value, out_ch.end_of_set);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** quicksort_hoare_median3: FAILED **");
        $finish;
      end
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  task automatic send_sample(logic signed [31:0] value, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_value <= value;
    in_ch.final_item <= last;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    board.note_sample(value, last);
  endtask

  function automatic logic signed [31:0] rand_value(int unsigned style);
    case (style)
      0: rand_value = $urandom_range(7) - 4;
      1: rand_value = 32'h8000_0000 + $urandom_range(3);
      2: rand_value = 32'h7fff_ffff - $urandom_range(3);
      default: rand_value = $urandom;
    endcase
  endfunction

  task automatic send_set(int unsigned count, int unsigned style);
    for (int k = 0; k < count; k++) begin
      send_sample(rand_value(style == 4 ? $urandom_range(3) : style), k == count - 1);
    end
  endtask

  task automatic random_sets(int unsigned item_goal);
    int unsigned sent;
    int unsigned count;
    sent = 0;
    while (sent < item_goal) begin
      count = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 20);
      send_set(count, $urandom_range(4));
      sent += count;
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_value = '0;
    in_ch.final_item = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_set(1, 3);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0000_0000, 1'b0);
    send_sample(32'shffff_ffff, 1'b1);
    send_set(3, 0);
    send_set(2, 1);
    for (int k = 0; k < 10; k++) begin
      send_sample(k, k == 9);
    end
    for (int k = 0; k < 64; k++) begin
      send_sample(64 - k, 1'b0);
    end
    random_sets(140);
    send_idle_pct = 62;
    recv_idle_pct = 8;
    random_sets(140);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_sets(140);
    in_ch.valid <= 1'b0;
    while (board.due_value.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
    if (board.error_count == 0) begin
      $display("** quicksort_hoare_median3: PASSED **");
    end else begin
      $display("** quicksort_hoare_median3: FAILED **");
    end
    $finish;
  end
endmodule
